/* design/veb_pkg.sv */
// Shared constants, codes and helper functions for the voice envelope bank.
package veb_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = SLOT_W + 1;
  localparam int DUMP_N    = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;

  localparam logic [7:0] RATE_STEP = 8'h24;
  localparam logic [7:0] SUS_STEP  = 8'h11;
  localparam logic [7:0] LEVEL_MAX = 8'hFF;

  // item actions
  localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [1:0] ACT_TICK     = 2'd2;
  localparam logic [1:0] ACT_FRAME    = 2'd3;

  // instrument kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_SCALED = 2'd1;

  // envelope phases
  localparam logic [2:0] PH_ATTACK  = 3'd0;
  localparam logic [2:0] PH_DECAY   = 3'd1;
  localparam logic [2:0] PH_SUSTAIN = 3'd2;
  localparam logic [2:0] PH_RELEASE = 3'd3;
  localparam logic [2:0] PH_ENDED   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_LOAD,
    ST_WALK
  } veb_state_t;

  // (7 - x) * 0x24, never below 1
  function automatic logic [7:0] scaled_rate(input logic [2:0] x);
    logic [7:0] diff;
    logic [7:0] r;
    diff = {5'd0, 3'd7 - x};
    r    = 8'(diff * RATE_STEP);
    if (r == 8'd0) begin
      r = 8'd1;
    end
    return r;
  endfunction

  function automatic logic [7:0] scaled_sustain(input logic [3:0] x);
    return 8'({4'd0, x} * SUS_STEP);
  endfunction

endpackage

/* design/voice_envelope_bank.sv */
// Voice envelope bank: 16 voice slots with ADSR envelopes, one slot update per cycle.
//
// Items enter one at a time: in_stall is high from the transfer of an item until its
// sequencer walk is over. A note-on scans the busy bits one slot per cycle for the lowest
// free slot (slot 0 when all are busy), then loads it once the result register is free,
// giving one result. A note-off, a length tick or an envelope frame walks all NUM_SLOTS
// slots through the single slot update unit, one slot per cycle, giving one result per
// slot (slots 0 to 15, the last one flagged). A stalled result register holds the walk.
// The next item can be taken while the final result still waits on out_stall.
module voice_envelope_bank
  import veb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [3:0] in_channel,
  input  logic [6:0] in_note,
  input  logic [9:0] in_note_length,
  input  logic [1:0] in_inst_kind,
  input  logic [7:0] in_attack_byte,
  input  logic [7:0] in_decay_byte,
  input  logic [7:0] in_sustain_byte,
  input  logic [7:0] in_release_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_slot_index,
  output logic [7:0] out_level,
  output logic [2:0] out_phase,
  output logic       out_busy_res,
  output logic       out_last
);

  // slot state
  logic [3:0]           owner_r   [NUM_SLOTS];
  logic [6:0]           pnote_r   [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] in_use_r;
  logic [2:0]           phase_r   [NUM_SLOTS];
  logic [7:0]           level_r   [NUM_SLOTS];
  logic [7:0]           ratk_r    [NUM_SLOTS];
  logic [7:0]           rdec_r    [NUM_SLOTS];
  logic [7:0]           sus_r     [NUM_SLOTS];
  logic [7:0]           rrel_r    [NUM_SLOTS];
  logic [9:0]           ticks_r   [NUM_SLOTS];

  // held item
  logic [1:0] act_r;
  logic [3:0] chan_r;
  logic [6:0] note_r;
  logic [9:0] len_r;
  logic [1:0] kind_r;
  logic [7:0] atk_b_r, dec_b_r, sus_b_r, rel_b_r;

  veb_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, pick_r;

  logic out_valid_r, out_last_r, out_busy_r;
  logic [3:0] out_slot_r;
  logic [7:0] out_level_r;
  logic [2:0] out_phase_r;

  // control
  logic accept, out_free, at_end, emit_here, step;
  logic slot_wr, out_load, idx_clr, idx_inc, pick_ld;

  // slot update unit
  logic [SLOT_W-1:0] sel;
  logic [2:0] cur_ph, nx_ph;
  logic [7:0] cur_lv, nx_lv, nx_ratk, nx_rdec, nx_sus, nx_rrel;
  logic [9:0] nx_ticks;
  logic [3:0] nx_owner;
  logic [6:0] nx_pnote;
  logic       nx_busy;
  logic [8:0] sum9;
  logic [7:0] diff;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign at_end    = (idx_r == SLOT_W'(NUM_SLOTS - 1));
  assign emit_here = (CNT_W'(idx_r) < CNT_W'(DUMP_N));
  assign step      = out_free || !emit_here;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_action == ACT_NOTE_ON) ? ST_FIND : ST_WALK;
        end
      end
      ST_FIND: begin
        if (!in_use_r[idx_r] || at_end) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (step && at_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    slot_wr  = 1'b0;
    out_load = 1'b0;
    idx_clr  = 1'b0;
    idx_inc  = 1'b0;
    pick_ld  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        idx_clr = in_valid;
      end
      ST_FIND: begin
        pick_ld = !in_use_r[idx_r] || at_end;
        idx_inc = in_use_r[idx_r] && !at_end;
      end
      ST_LOAD: begin
        slot_wr  = out_free;
        out_load = out_free;
      end
      ST_WALK: begin
        slot_wr  = step;
        out_load = step && emit_here;
        idx_inc  = step && !at_end;
      end
      default: ;
    endcase
  end

  assign sel    = (state_r == ST_LOAD) ? pick_r : idx_r;
  assign cur_ph = phase_r[sel];
  assign cur_lv = level_r[sel];
  assign sum9   = {1'b0, cur_lv} + {1'b0, ratk_r[sel]};

  always_comb begin
    nx_owner = owner_r[sel];
    nx_pnote = pnote_r[sel];
    nx_busy  = in_use_r[sel];
    nx_ph    = cur_ph;
    nx_lv    = cur_lv;
    nx_ratk  = ratk_r[sel];
    nx_rdec  = rdec_r[sel];
    nx_sus   = sus_r[sel];
    nx_rrel  = rrel_r[sel];
    nx_ticks = ticks_r[sel];
    diff     = 8'd0;
    if (state_r == ST_LOAD) begin
      nx_owner = chan_r;
      nx_pnote = note_r;
      nx_busy  = 1'b1;
      nx_ticks = len_r;
      if (kind_r == KIND_SAMPLE) begin
        nx_ph   = PH_ATTACK;
        nx_lv   = 8'd0;
        nx_ratk = atk_b_r;
        nx_rdec = dec_b_r;
        nx_sus  = sus_b_r;
        nx_rrel = rel_b_r;
      end else if (kind_r == KIND_SCALED) begin
        nx_ph   = PH_ATTACK;
        nx_lv   = 8'd0;
        nx_ratk = scaled_rate(atk_b_r[2:0]);
        nx_rdec = scaled_rate(dec_b_r[2:0]);
        nx_sus  = scaled_sustain(sus_b_r[3:0]);
        nx_rrel = scaled_rate(rel_b_r[2:0]);
      end
    end else begin
      unique case (act_r)
        ACT_NOTE_OFF: begin
          if (owner_r[sel] == chan_r && pnote_r[sel] == note_r) begin
            nx_busy = 1'b0;
            nx_ph   = PH_RELEASE;
            nx_lv   = sus_r[sel];
          end
        end
        ACT_TICK: begin
          if (ticks_r[sel] != 10'd0) begin
            nx_ticks = ticks_r[sel] - 10'd1;
            if (ticks_r[sel] == 10'd1) begin
              nx_busy = 1'b0;
              nx_ph   = PH_RELEASE;
              nx_lv   = sus_r[sel];
            end
          end
        end
        ACT_FRAME: begin
          unique case (cur_ph)
            PH_ATTACK: begin
              if (sum9 >= {1'b0, LEVEL_MAX}) begin
                nx_lv = LEVEL_MAX;
                nx_ph = PH_DECAY;
              end else begin
                nx_lv = sum9[7:0];
              end
            end
            PH_DECAY: begin
              diff = cur_lv - rdec_r[sel];
              if (cur_lv < rdec_r[sel] || diff <= sus_r[sel]) begin
                nx_lv = sus_r[sel];
                nx_ph = PH_SUSTAIN;
              end else begin
                nx_lv = diff;
              end
            end
            PH_SUSTAIN: begin
              nx_lv = sus_r[sel];
            end
            PH_RELEASE: begin
              if (cur_lv <= rrel_r[sel]) begin
                nx_lv   = 8'd0;
                nx_ph   = PH_ENDED;
                nx_busy = 1'b0;
              end else begin
                nx_lv = cur_lv - rrel_r[sel];
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      pick_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (idx_clr) begin
        idx_r <= '0;
      end else if (idx_inc) begin
        idx_r <= idx_r + SLOT_W'(1);
      end
      if (pick_ld) begin
        pick_r <= in_use_r[idx_r] ? '0 : idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= in_action;
      chan_r  <= in_channel;
      note_r  <= in_note;
      len_r   <= in_note_length;
      kind_r  <= in_inst_kind;
      atk_b_r <= in_attack_byte;
      dec_b_r <= in_decay_byte;
      sus_b_r <= in_sustain_byte;
      rel_b_r <= in_release_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        owner_r[i] <= '0;
        pnote_r[i] <= '0;
        phase_r[i] <= '0;
        level_r[i] <= '0;
        ratk_r[i]  <= '0;
        rdec_r[i]  <= '0;
        sus_r[i]   <= '0;
        rrel_r[i]  <= '0;
        ticks_r[i] <= '0;
      end
    end else if (slot_wr) begin
      owner_r[sel]  <= nx_owner;
      pnote_r[sel]  <= nx_pnote;
      in_use_r[sel] <= nx_busy;
      phase_r[sel]  <= nx_ph;
      level_r[sel]  <= nx_lv;
      ratk_r[sel]   <= nx_ratk;
      rdec_r[sel]   <= nx_rdec;
      sus_r[sel]    <= nx_sus;
      rrel_r[sel]   <= nx_rrel;
      ticks_r[sel]  <= nx_ticks;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slot_r  <= 4'(sel);
      out_level_r <= nx_lv;
      out_phase_r <= nx_ph;
      out_busy_r  <= nx_busy;
      out_last_r  <= (state_r == ST_LOAD) || (idx_r == SLOT_W'(DUMP_N - 1));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_slot_index = out_slot_r;
  assign out_level      = out_level_r;
  assign out_phase      = out_phase_r;
  assign out_busy_res   = out_busy_r;
  assign out_last       = out_last_r;

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !slot_wr)
    else $error("slot written while idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");

  a_pick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && slot_wr) |=> in_use_r[$past(pick_r)])
    else $error("claimed slot not busy");

  a_find_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIND && !in_use_r[idx_r]) |=> (pick_r == $past(idx_r)))
    else $error("note-on skipped a free slot");

endmodule

/* sim/voice_envelope_bank_tb.sv */
// Self-checking envelope bank testbench: directed and random traffic against a slot-level model.
`timescale 1ns / 1ps

module voice_envelope_bank_tb
  import veb_pkg::*;
;

  localparam logic [1:0] KIND_INVALID    = 2'd2;
  localparam logic [1:0] KIND_INVALID_HI = 2'd3;
  localparam int RANDOM_CMDS  = 250;
  localparam int STUCK_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] channel;
    logic [6:0] note;
    logic [9:0] length;
    logic [1:0] kind;
    logic [7:0] atk;
    logic [7:0] dec;
    logic [7:0] sus;
    logic [7:0] rel;
  } voice_cmd_t;

  typedef struct packed {
    logic [3:0] slot;
    logic [7:0] level;
    logic [2:0] phase;
    logic       busy;
    logic       last;
  } slot_report_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_action = '0;
  logic [3:0] in_channel = '0;
  logic [6:0] in_note = '0;
  logic [9:0] in_note_length = '0;
  logic [1:0] in_inst_kind = '0;
  logic [7:0] in_attack_byte = '0;
  logic [7:0] in_decay_byte = '0;
  logic [7:0] in_sustain_byte = '0;
  logic [7:0] in_release_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] out_slot_index;
  logic [7:0] out_level;
  logic [2:0] out_phase;
  logic       out_busy_res;
  logic       out_last;

  voice_envelope_bank u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_channel      (in_channel),
    .in_note         (in_note),
    .in_note_length  (in_note_length),
    .in_inst_kind    (in_inst_kind),
    .in_attack_byte  (in_attack_byte),
    .in_decay_byte   (in_decay_byte),
    .in_sustain_byte (in_sustain_byte),
    .in_release_byte (in_release_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_slot_index  (out_slot_index),
    .out_level       (out_level),
    .out_phase       (out_phase),
    .out_busy_res    (out_busy_res),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the slot bank
  logic [3:0] bank_owner   [NUM_SLOTS];
  logic [6:0] bank_note    [NUM_SLOTS];
  logic       bank_busy    [NUM_SLOTS];
  logic [2:0] bank_phase   [NUM_SLOTS];
  logic [7:0] bank_level   [NUM_SLOTS];
  logic [7:0] bank_atk     [NUM_SLOTS];
  logic [7:0] bank_dec     [NUM_SLOTS];
  logic [7:0] bank_sus     [NUM_SLOTS];
  logic [7:0] bank_rel     [NUM_SLOTS];
  logic [9:0] bank_ticks   [NUM_SLOTS];

  voice_cmd_t   note_events[$];
  slot_report_t slot_reports_due[$];
  int           errors = 0;
  int           quiet_cycles = 0;

  function automatic logic [7:0] tone_rate(input logic [7:0] b);
    logic [7:0] r;
    r = 8'((8'd7 - {5'd0, b[2:0]}) * 8'h24);
    if (r == 8'd0) begin
      r = 8'd1;
    end
    return r;
  endfunction

  task automatic push_report(input int s, input logic is_last);
    slot_report_t rep;
    rep.slot  = 4'(s);
    rep.level = bank_level[s];
    rep.phase = bank_phase[s];
    rep.busy  = bank_busy[s];
    rep.last  = is_last;
    slot_reports_due.push_back(rep);
  endtask

  task automatic release_slot(input int s);
    bank_busy[s]  = 1'b0;
    bank_phase[s] = PH_RELEASE;
    bank_level[s] = bank_sus[s];
  endtask

  // apply one command to the shadow bank and queue the reports it causes
  task automatic step_voice_bank(input voice_cmd_t c);
    int pick;
    int s;
    int lv;
    if (c.action == ACT_NOTE_ON) begin
      pick = 0;
      for (s = NUM_SLOTS - 1; s >= 0; s--) begin
        if (!bank_busy[s]) pick = s;
      end
      bank_owner[pick] = c.channel;
      bank_note[pick]  = c.note;
      bank_busy[pick]  = 1'b1;
      bank_ticks[pick] = c.length;
      case (c.kind)
        KIND_SAMPLE: begin
          bank_phase[pick] = PH_ATTACK;
          bank_level[pick] = 8'd0;
          bank_atk[pick]   = c.atk;
          bank_dec[pick]   = c.dec;
          bank_sus[pick]   = c.sus;
          bank_rel[pick]   = c.rel;
        end
        KIND_SCALED: begin
          bank_phase[pick] = PH_ATTACK;
          bank_level[pick] = 8'd0;
          bank_atk[pick]   = tone_rate(c.atk);
          bank_dec[pick]   = tone_rate(c.dec);
          bank_sus[pick]   = 8'({4'd0, c.sus[3:0]} * 8'h11);
          bank_rel[pick]   = tone_rate(c.rel);
        end
        default: ;  // invalid kind: slot claimed, envelope untouched
      endcase
      push_report(pick, 1'b1);
    end else begin
      for (s = 0; s < NUM_SLOTS; s++) begin
        case (c.action)
          ACT_NOTE_OFF: begin
            // matches on owner and note even for free slots
            if (bank_owner[s] == c.channel && bank_note[s] == c.note) release_slot(s);
          end
          ACT_TICK: begin
            if (bank_ticks[s] != 10'd0) begin
              bank_ticks[s] = bank_ticks[s] - 10'd1;
              if (bank_ticks[s] == 10'd0) release_slot(s);
            end
          end
          default: begin
            lv = int'(bank_level[s]);
            case (bank_phase[s])
              PH_ATTACK: begin
                lv = lv + int'(bank_atk[s]);
                if (lv >= int'(LEVEL_MAX)) begin
                  lv = int'(LEVEL_MAX);
                  bank_phase[s] = PH_DECAY;
                end
              end
              PH_DECAY: begin
                lv = lv - int'(bank_dec[s]);
                if (lv <= int'(bank_sus[s])) begin
                  lv = int'(bank_sus[s]);
                  bank_phase[s] = PH_SUSTAIN;
                end
              end
              PH_SUSTAIN: lv = int'(bank_sus[s]);
              PH_RELEASE: begin
                lv = lv - int'(bank_rel[s]);
                if (lv <= 0) begin
                  lv = 0;
                  bank_phase[s] = PH_ENDED;
                  bank_busy[s]  = 1'b0;
                end
              end
              default: ;
            endcase
            bank_level[s] = 8'(lv);
          end
        endcase
      end
      for (s = 0; s < DUMP_N; s++) begin
        push_report(s, s == DUMP_N - 1);
      end
    end
  endtask

  task automatic queue_cmd(input logic [1:0] action, input logic [3:0] ch,
                           input logic [6:0] note, input logic [9:0] len,
                           input logic [1:0] kind, input logic [7:0] a,
                           input logic [7:0] d, input logic [7:0] su, input logic [7:0] r);
    voice_cmd_t c;
    c = '{action, ch, note, len, kind, a, d, su, r};
    note_events.push_back(c);
  endtask

  // driver: bursts of transfers separated by random gaps
  voice_cmd_t cur_cmd;
  int         burst_left = 1;
  int         gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) step_voice_bank(cur_cmd);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (note_events.size() > 0) begin
        cur_cmd = note_events.pop_front();
        in_action       <= cur_cmd.action;
        in_channel      <= cur_cmd.channel;
        in_note         <= cur_cmd.note;
        in_note_length  <= cur_cmd.length;
        in_inst_kind    <= cur_cmd.kind;
        in_attack_byte  <= cur_cmd.atk;
        in_decay_byte   <= cur_cmd.dec;
        in_sustain_byte <= cur_cmd.sus;
        in_release_byte <= cur_cmd.rel;
        in_valid        <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          case ($urandom_range(0, 3))
            0:       gap_left = 0;
            1:       gap_left = $urandom_range(4, 24);
            default: gap_left = $urandom_range(0, 2);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall pattern
  slot_report_t got;
  slot_report_t want;
  int           stall_mode = 0;
  int           stall_hold = 0;
  int           stall_tick = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got = {out_slot_index, out_level, out_phase, out_busy_res, out_last};
      if (slot_reports_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected report: expected none, actual slot %0d level %0d",
                 $time, got.slot, got.level,
                 " phase %0d busy %0b last %0b", got.phase, got.busy, got.last);
      end else begin
        want = slot_reports_due.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: report mismatch: expected slot %0d level %0d phase %0d",
                   $time, want.slot, want.level, want.phase,
                   " busy %0b last %0b, actual slot %0d level %0d phase %0d",
                   want.busy, want.last, got.slot, got.level, got.phase,
                   " busy %0b last %0b", got.busy, got.last);
        end
      end
    end
    stall_tick++;
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_hold = $urandom_range(16, 96);
    end else begin
      stall_hold--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (stall_tick % 3 == 0);
    endcase
  end

  // cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    voice_cmd_t c;
    int r;
    int i;
    rst_n = 1'b0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      bank_owner[i] = '0;
      bank_note[i]  = '0;
      bank_busy[i]  = 1'b0;
      bank_phase[i] = PH_ATTACK;
      bank_level[i] = '0;
      bank_atk[i]   = '0;
      bank_dec[i]   = '0;
      bank_sus[i]   = '0;
      bank_rel[i]   = '0;
      bank_ticks[i] = '0;
    end

    // directed: reset state, idle-slot note-off, field extremes, every kind
    queue_cmd(ACT_FRAME,    4'd0,  7'd0,   10'd0,    KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_NOTE_OFF, 4'd0,  7'd0,   10'd0,    KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_FRAME,    4'd0,  7'd0,   10'd0,    KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_NOTE_ON,  4'd0,  7'd0,   10'd0,    KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_NOTE_ON,  4'd15, 7'd127, 10'd1023, KIND_SAMPLE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_cmd(ACT_NOTE_ON,  4'd5,  7'd60,  10'd2,    KIND_SCALED, 8'h07, 8'h07, 8'h0F, 8'h07);
    queue_cmd(ACT_NOTE_ON,  4'd6,  7'd61,  10'd1,    KIND_SCALED, 8'hF8, 8'hF8, 8'hF0, 8'hF8);
    queue_cmd(ACT_NOTE_ON,  4'd7,  7'd62,  10'd0,    KIND_INVALID, 8'hAA, 8'h55, 8'hAA, 8'h55);
    queue_cmd(ACT_NOTE_ON,  4'd8,  7'd63,  10'd3,    KIND_INVALID_HI, 8'h55, 8'hAA, 8'h55, 8'hAA);
    queue_cmd(ACT_NOTE_ON,  4'd9,  7'd64,  10'd0,    KIND_SAMPLE, 8'h80, 8'h10, 8'h40, 8'h30);
    queue_cmd(ACT_FRAME,    4'd0,  7'd0,   10'd0,    KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_FRAME,    4'd0,  7'd0,   10'd0,    KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_FRAME,    4'd0,  7'd0,   10'd0,    KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_TICK,     4'd0,  7'd0,   10'd0,    KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_TICK,     4'd0,  7'd0,   10'd0,    KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_NOTE_OFF, 4'd15, 7'd127, 10'd0,    KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_NOTE_OFF, 4'd9,  7'd9,   10'd0,    KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_FRAME,    4'd0,  7'd0,   10'd0,    KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_FRAME,    4'd0,  7'd0,   10'd0,    KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_NOTE_OFF, 4'd9,  7'd64,  10'd0,    KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_FRAME,    4'd0,  7'd0,   10'd0,    KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_cmd(ACT_FRAME,    4'd0,  7'd0,   10'd0,    KIND_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00);

    // random: a few channels and notes so note-offs hit, slots fill up and get stolen
    for (i = 0; i < RANDOM_CMDS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      c.action = ACT_NOTE_ON;
      else if (r < 55) c.action = ACT_NOTE_OFF;
      else if (r < 72) c.action = ACT_TICK;
      else             c.action = ACT_FRAME;
      c.channel = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
      c.note    = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'(40 + $urandom_range(0, 5));
      c.length  = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 6));
      if ($urandom_range(0, 9) == 0) c.kind = 2'($urandom);
      else c.kind = $urandom_range(0, 1) ? KIND_SCALED : KIND_SAMPLE;
      c.atk = 8'($urandom);
      c.dec = 8'($urandom);
      c.sus = 8'($urandom);
      c.rel = 8'($urandom);
      note_events.push_back(c);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (!(note_events.size() == 0 && !in_valid && slot_reports_due.size() == 0)
           && quiet_cycles < STUCK_LIMIT)
      @(posedge clk);
    if (quiet_cycles < STUCK_LIMIT) repeat (DRAIN_CYCLES) @(posedge clk);
    if (quiet_cycles >= STUCK_LIMIT || slot_reports_due.size() != 0) errors++;

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/veb_pkg.sv
design/voice_envelope_bank.sv
sim/voice_envelope_bank_tb.sv
